// ===== rtl/fcf_pkg.sv =====
// fcf_pkg: sizes, item codes, state machine type and controller/datapath structs
// for the circular-history fir filter; no dependencies
`default_nettype none

package fcf_pkg;

  localparam int MAX_TAPS = 256;
  localparam int SAMPLE_W = 16;
  localparam int IDX_W    = $clog2(MAX_TAPS);
  localparam int CNT_W    = $clog2(MAX_TAPS + 1);
  localparam int PROD_W   = 2 * SAMPLE_W;
  localparam int ACC_W    = 40;
  localparam int TAPC_W   = 9;
  localparam int KIND_W   = 2;
  localparam int TIDX_W   = 8;
  localparam int APB_AW   = 2;
  localparam int APB_DW   = 32;

  localparam logic [KIND_W-1:0] KIND_SAMPLE = 2'd0;
  localparam logic [KIND_W-1:0] KIND_COEF   = 2'd1;
  localparam logic [KIND_W-1:0] KIND_FILL   = 2'd2;

  localparam logic [APB_AW-1:0] REG_TAP_COUNT = 2'd0;
  localparam logic [TAPC_W-1:0] TAP_COUNT_RST = 9'd256;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_DRAIN
  } fcf_state_t;

  typedef struct packed {
    logic start;
    logic coef_wr;
    logic fill;
    logic issue;
    logic load_out;
  } fcf_cmd_t;

  typedef struct packed {
    logic last_tap;
    logic pipe_busy;
    logic out_free;
  } fcf_sts_t;

endpackage

`default_nettype wire

// ===== rtl/fcf_ctrl.sv =====
// fcf_ctrl: sequencer for the fir filter, decodes item kinds and steps the mac
// depends on fcf_pkg
`default_nettype none

module fcf_ctrl
  import fcf_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  input  wire logic [KIND_W-1:0] in_kind,
  output logic                   in_stall,
  input  wire fcf_sts_t          sts,
  output fcf_cmd_t               cmd
);

  fcf_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid && (in_kind == KIND_SAMPLE)) begin
          state_nxt = ST_RUN;
        end
      end
      ST_RUN: begin
        if (sts.last_tap) begin
          state_nxt = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (!sts.pipe_busy && sts.out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_stall = 1'b1;
    unique case (state_r)
      ST_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          cmd.start   = (in_kind == KIND_SAMPLE);
          cmd.coef_wr = (in_kind == KIND_COEF);
          cmd.fill    = (in_kind == KIND_FILL);
        end
      end
      ST_RUN: begin
        cmd.issue = 1'b1;
      end
      ST_DRAIN: begin
        cmd.load_out = !sts.pipe_busy && sts.out_free;
      end
      default: begin
        cmd = '0;
      end
    endcase
  end

endmodule

`default_nettype wire

// ===== rtl/fcf_datapath.sv =====
// fcf_datapath: history and coefficient stores, pointers, serial mac and result register
// depends on fcf_pkg
`default_nettype none

module fcf_datapath
  import fcf_pkg::*;
(
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire fcf_cmd_t                 cmd,
  output fcf_sts_t                      sts,
  input  wire logic signed [SAMPLE_W-1:0] in_value,
  input  wire logic [TIDX_W-1:0]        in_tap_index,
  input  wire logic [TAPC_W-1:0]        tap_count,
  output logic                          out_valid,
  input  wire logic                     out_stall,
  output logic signed [ACC_W-1:0]       out_filtered
);

  logic signed [SAMPLE_W-1:0] hist_mem [MAX_TAPS];
  logic signed [SAMPLE_W-1:0] coef_mem [MAX_TAPS];
  logic [MAX_TAPS-1:0]        hist_vld_r;
  logic signed [SAMPLE_W-1:0] fill_r;

  logic [IDX_W-1:0] wp_r;
  logic [IDX_W-1:0] ptr_r;
  logic [IDX_W-1:0] tap_r;
  logic [CNT_W-1:0] n_r;

  logic [CNT_W-1:0] n_eff;
  logic [IDX_W-1:0] wp_eff;
  logic [IDX_W-1:0] wp_step;

  logic signed [SAMPLE_W-1:0] hist_q_r;
  logic signed [SAMPLE_W-1:0] coef_q_r;
  logic                       vld_q_r;
  logic                       rd_vld_r;
  logic signed [PROD_W-1:0]   prod_r;
  logic                       mul_vld_r;
  logic signed [ACC_W-1:0]    acc_r;
  logic                       out_valid_r;
  logic signed [ACC_W-1:0]    out_data_r;
  logic signed [SAMPLE_W-1:0] hist_op;

  // zero taps behaves as one, oversize saturates
  always_comb begin
    if (tap_count == '0) begin
      n_eff = CNT_W'(1);
    end else if (int'(tap_count) > MAX_TAPS) begin
      n_eff = CNT_W'(MAX_TAPS);
    end else begin
      n_eff = CNT_W'(tap_count);
    end
    wp_eff  = (CNT_W'(wp_r) < n_eff) ? wp_r : '0;
    wp_step = ((CNT_W'(wp_eff) + CNT_W'(1)) >= n_eff) ? '0 : (wp_eff + IDX_W'(1));
  end

  // history store, write on sample transfer, registered read during the run
  always_ff @(posedge clk) begin
    if (cmd.start) begin
      hist_mem[wp_eff] <= in_value;
    end
    hist_q_r <= hist_mem[ptr_r];
  end

  always_ff @(posedge clk) begin
    if (cmd.coef_wr && (int'(in_tap_index) < MAX_TAPS)) begin
      coef_mem[IDX_W'(in_tap_index)] <= in_value;
    end
    coef_q_r <= coef_mem[tap_r];
  end

  // an entry without its valid bit reads as the last fill value
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hist_vld_r <= '0;
      fill_r     <= '0;
    end else if (cmd.fill) begin
      hist_vld_r <= '0;
      fill_r     <= in_value;
    end else if (cmd.start) begin
      hist_vld_r[wp_eff] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    vld_q_r <= hist_vld_r[ptr_r];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r <= '0;
    end else if (cmd.start) begin
      wp_r <= wp_step;
    end
  end

  // newest sample first, walking back with wrap
  always_ff @(posedge clk) begin
    if (cmd.start) begin
      ptr_r <= wp_eff;
      tap_r <= '0;
      n_r   <= n_eff;
    end else if (cmd.issue) begin
      ptr_r <= (ptr_r == '0) ? IDX_W'(n_r - CNT_W'(1)) : (ptr_r - IDX_W'(1));
      tap_r <= tap_r + IDX_W'(1);
    end
  end

  assign hist_op = vld_q_r ? hist_q_r : fill_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_vld_r  <= 1'b0;
      mul_vld_r <= 1'b0;
    end else begin
      rd_vld_r  <= cmd.issue;
      mul_vld_r <= rd_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    prod_r <= hist_op * coef_q_r;
  end

  // sum wraps modulo the accumulator width
  always_ff @(posedge clk) begin
    if (cmd.start) begin
      acc_r <= '0;
    end else if (mul_vld_r) begin
      acc_r <= acc_r + ACC_W'(prod_r);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      out_data_r <= acc_r;
    end
  end

  assign sts.last_tap  = ((CNT_W'(tap_r) + CNT_W'(1)) == n_r);
  assign sts.pipe_busy = rd_vld_r || mul_vld_r;
  assign sts.out_free  = !out_valid_r || !out_stall;

  assign out_valid    = out_valid_r;
  assign out_filtered = out_data_r;

endmodule

`default_nettype wire

// ===== rtl/fir_filter_circular_unit.sv =====
// fir_filter_circular_unit: top level of the circular-history fir filter,
// holds the tap count register; depends on fcf_pkg, fcf_ctrl, fcf_datapath
//
//   channel   direction  handshake            payload
//   in_       input      in_valid / in_stall  in_kind, in_value, in_tap_index
//   out_      output     out_valid/out_stall  out_filtered
//   cfg (apb) input      psel/penable/pready  paddr, pwdata, prdata (tap_count at 0)
//
// a sample does one multiply-accumulate per tap in use through the single mac,
// then waits for the read and multiply pipeline to drain and the output to be free
// before the result load; coefficient and fill items are taken without leaving idle
// rst_n is synchronous; history reads as zero after reset, tap count resets to 256
// a waiting result holds in the output register while the next item is taken in
`default_nettype none

module fir_filter_circular_unit
  import fcf_pkg::*;
(
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       in_valid,
  output logic                            in_stall,
  input  wire logic [KIND_W-1:0]          in_kind,
  input  wire logic signed [SAMPLE_W-1:0] in_value,
  input  wire logic [TIDX_W-1:0]          in_tap_index,
  output logic                            out_valid,
  input  wire logic                       out_stall,
  output logic signed [ACC_W-1:0]         out_filtered,
  input  wire logic                       psel,
  input  wire logic                       penable,
  input  wire logic                       pwrite,
  input  wire logic [APB_AW-1:0]          paddr,
  input  wire logic [APB_DW-1:0]          pwdata,
  output logic [APB_DW-1:0]               prdata,
  output logic                            pready
);

  fcf_cmd_t          cmd;
  fcf_sts_t          sts;
  logic [TAPC_W-1:0] tap_count_r;

  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tap_count_r <= TAP_COUNT_RST;
    end else if (psel && penable && pwrite && (paddr == REG_TAP_COUNT)) begin
      tap_count_r <= pwdata[TAPC_W-1:0];
    end
  end

  assign prdata = (paddr == REG_TAP_COUNT) ? APB_DW'(tap_count_r) : '0;

  fcf_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_kind  (in_kind),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  fcf_datapath u_datapath (
    .clk          (clk),
    .rst_n        (rst_n),
    .cmd          (cmd),
    .sts          (sts),
    .in_value     (in_value),
    .in_tap_index (in_tap_index),
    .tap_count    (tap_count_r),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_filtered (out_filtered)
  );

endmodule

`default_nettype wire
